>>> rtl/pshq_pkg.sv
// package for polyline_store_height_query: constants, types
// no dependencies
package pshq_pkg;
  localparam int MaxSegments = 256;
  localparam int AddrW = $clog2(MaxSegments);
  localparam int CntW = $clog2(MaxSegments + 1);

  typedef enum logic [2:0] {
    FUNC_CLICK = 3'd0, FUNC_NEW = 3'd1, FUNC_UNDO = 3'd2, FUNC_REDO = 3'd3,
    FUNC_QUERY = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE_RD, S_MOVE_WR, S_SCAN_RD, S_SCAN_CHK, S_PREP, S_DIV, S_OUT
  } state_t;
endpackage

>>> rtl/polyline_store_height_query.sv
// polyline_store_height_query: segment stack, redo stack, height query
// depends on pshq_pkg
// one item at a time, the next accepted once the result is taken; a query's time is set by
// the scan of the segment memory, a read state and a check state an entry (one read port),
// and a 32-step restoring divider
// reset: synchronous active-low rst_n empties both stacks and clears the anchor;
// memories are not cleared
module polyline_store_height_query (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[2:0], point_x[14:3], point_y[26:15], query_x[46:27]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // found[0], height[20:1], line_count[29:21],
                                  // redo_count[38:30], status[40:39]
);
  localparam int AW = pshq_pkg::AddrW;
  localparam int CW = pshq_pkg::CntW;
  localparam logic [CW-1:0] Full = CW'(pshq_pkg::MaxSegments);

  logic [47:0] seg_mem [pshq_pkg::MaxSegments];
  logic [47:0] redo_mem [pshq_pkg::MaxSegments];

  pshq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] seg_top_r, seg_top_nxt, redo_top_r, redo_top_nxt;
  logic [11:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [2:0] func_r, func_nxt;
  logic [19:0] qx_r, qx_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [47:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic rd_seg, rd_redo;
  logic seg_we, redo_we;
  logic [AW-1:0] wr_addr;
  logic [47:0] wr_data;
  logic found_r, found_nxt;
  logic [1:0] status_r, status_nxt;
  logic [31:0] rem_r, rem_nxt;    // partial remainder
  logic [31:0] quo_r, quo_nxt;    // dividend shifting into quotient
  logic [11:0] dx_r, dx_nxt;
  logic [5:0] step_r, step_nxt;
  logic [47:0] out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  // memories
  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[wr_addr] <= wr_data;
    if (redo_we) redo_mem[wr_addr] <= wr_data;
    if (rd_seg) rd_r <= seg_mem[rd_addr];
    else if (rd_redo) rd_r <= redo_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pshq_pkg::S_IDLE;
      seg_top_r <= '0;
      redo_top_r <= '0;
      ax_r <= '0;
      ay_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_top_r <= seg_top_nxt;
      redo_top_r <= redo_top_nxt;
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    qx_r <= qx_nxt;
    idx_r <= idx_nxt;
    found_r <= found_nxt;
    status_r <= status_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dx_r <= dx_nxt;
    step_r <= step_nxt;
    out_r <= out_nxt;
  end

  assign in_tready = (state_r == pshq_pkg::S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  logic [11:0] sx1, sy1, sx2, sy2;
  logic [19:0] x1s, x2s;
  logic hit;
  logic [12:0] dy;
  logic [20:0] tq;
  logic signed [33:0] num;
  logic [32:0] trial;

  always_comb begin
    sx1 = rd_r[47:36];
    sy1 = rd_r[35:24];
    sx2 = rd_r[23:12];
    sy2 = rd_r[11:0];
    x1s = {sx1, 8'd0};
    x2s = {sx2, 8'd0};
    hit = (x1s < qx_r) && (qx_r < x2s);
    dy = 13'({1'b0, sy2}) - 13'({1'b0, sy1});
    tq = 21'(qx_r) - 21'(x1s);
    num = 34'(signed'({1'b0, sy1, 8'd0})) * 34'(signed'({1'b0, sx2 - sx1}))
        + 34'(signed'(dy)) * 34'(signed'(tq));
    trial = {rem_r, quo_r[31]} - {21'd0, dx_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pshq_pkg::S_IDLE:
        if (in_tvalid && in_tready) begin
          case (pshq_pkg::func_t'(in_tdata[2:0]))
            pshq_pkg::FUNC_UNDO:
              if (seg_top_r != '0 && redo_top_r != Full) state_nxt = pshq_pkg::S_MOVE_RD;
              else state_nxt = pshq_pkg::S_OUT;
            pshq_pkg::FUNC_REDO:
              if (redo_top_r != '0 && seg_top_r != Full) state_nxt = pshq_pkg::S_MOVE_RD;
              else state_nxt = pshq_pkg::S_OUT;
            pshq_pkg::FUNC_QUERY:
              if (seg_top_r != '0) state_nxt = pshq_pkg::S_SCAN_RD;
              else state_nxt = pshq_pkg::S_OUT;
            default: state_nxt = pshq_pkg::S_OUT;
          endcase
        end
      pshq_pkg::S_MOVE_RD: state_nxt = pshq_pkg::S_MOVE_WR;
      pshq_pkg::S_MOVE_WR: state_nxt = pshq_pkg::S_OUT;
      pshq_pkg::S_SCAN_RD: state_nxt = pshq_pkg::S_SCAN_CHK;
      pshq_pkg::S_SCAN_CHK:
        if (hit) state_nxt = pshq_pkg::S_PREP;
        else if (idx_r + 1'b1 == seg_top_r) state_nxt = pshq_pkg::S_OUT;
        else state_nxt = pshq_pkg::S_SCAN_RD;
      pshq_pkg::S_PREP: state_nxt = pshq_pkg::S_DIV;
      pshq_pkg::S_DIV: if (step_r == 6'd31) state_nxt = pshq_pkg::S_OUT;
      pshq_pkg::S_OUT: state_nxt = pshq_pkg::S_IDLE;
      default: state_nxt = pshq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seg_top_nxt = seg_top_r;
    redo_top_nxt = redo_top_r;
    ax_nxt = ax_r;
    ay_nxt = ay_r;
    func_nxt = func_r;
    qx_nxt = qx_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    status_nxt = status_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dx_nxt = dx_r;
    step_nxt = step_r;
    out_nxt = out_r;
    out_v_nxt = out_v_r;
    rd_addr = idx_r[AW-1:0];
    rd_seg = 1'b0;
    rd_redo = 1'b0;
    seg_we = 1'b0;
    redo_we = 1'b0;
    wr_addr = seg_top_r[AW-1:0];
    wr_data = {ax_r, ay_r, in_tdata[14:3], in_tdata[26:15]};
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    case (state_r)
      pshq_pkg::S_IDLE:
        if (in_tvalid && in_tready) begin
          func_nxt = in_tdata[2:0];
          qx_nxt = in_tdata[46:27];
          idx_nxt = '0;
          found_nxt = 1'b0;
          quo_nxt = '0;
          status_nxt = pshq_pkg::ST_DONE;
          case (pshq_pkg::func_t'(in_tdata[2:0]))
            pshq_pkg::FUNC_CLICK:
              if (ax_r == '0 && ay_r == '0) begin
                ax_nxt = in_tdata[14:3];
                ay_nxt = in_tdata[26:15];
              end else if (seg_top_r == Full) begin
                status_nxt = pshq_pkg::ST_FULL;
              end else begin
                seg_we = 1'b1;
                seg_top_nxt = seg_top_r + 1'b1;
                ax_nxt = in_tdata[14:3];
                ay_nxt = in_tdata[26:15];
              end
            pshq_pkg::FUNC_NEW: begin
              ax_nxt = '0;
              ay_nxt = '0;
            end
            pshq_pkg::FUNC_UNDO:
              if (seg_top_r == '0) status_nxt = pshq_pkg::ST_EMPTY;
              else if (redo_top_r == Full) status_nxt = pshq_pkg::ST_FULL;
            pshq_pkg::FUNC_REDO:
              if (redo_top_r == '0) status_nxt = pshq_pkg::ST_EMPTY;
              else if (seg_top_r == Full) status_nxt = pshq_pkg::ST_FULL;
            default: ;
          endcase
        end
      pshq_pkg::S_MOVE_RD:
        if (func_r == pshq_pkg::FUNC_UNDO) begin
          rd_addr = AW'(seg_top_r - 1'b1);
          rd_seg = 1'b1;
          seg_top_nxt = seg_top_r - 1'b1;
        end else begin
          rd_addr = AW'(redo_top_r - 1'b1);
          rd_redo = 1'b1;
          redo_top_nxt = redo_top_r - 1'b1;
        end
      pshq_pkg::S_MOVE_WR: begin
        wr_data = rd_r;
        if (func_r == pshq_pkg::FUNC_UNDO) begin
          wr_addr = redo_top_r[AW-1:0];
          redo_we = 1'b1;
          redo_top_nxt = redo_top_r + 1'b1;
        end else begin
          seg_we = 1'b1;
          seg_top_nxt = seg_top_r + 1'b1;
        end
      end
      pshq_pkg::S_SCAN_RD: rd_seg = 1'b1;
      pshq_pkg::S_SCAN_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          quo_nxt = num[33] ? 32'd0 : num[31:0];
          dx_nxt = sx2 - sx1;
        end
      end
      pshq_pkg::S_PREP: begin
        rem_nxt = '0;
        step_nxt = '0;
      end
      pshq_pkg::S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
      pshq_pkg::S_OUT: begin
        out_nxt = {7'd0, status_r, 9'(redo_top_r), 9'(seg_top_r), quo_r[19:0], found_r};
        out_v_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) seg_top_r <= Full && redo_top_r <= Full)
    else $error("stack top beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pshq_pkg::S_MOVE_WR |=> seg_top_r + redo_top_r == $past(seg_top_r + redo_top_r) + 1'b1)
    else $error("move lost a segment");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pshq_pkg::S_OUT |=> out_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");
endmodule

>>> sim/polyline_store_height_query_test.sv
// testbench for polyline_store_height_query: drives click, chain, undo, redo and
// height query items, predicts every result and compares it field by field
// depends on pshq_pkg and the block's rtl
module polyline_store_height_query_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] px;
    logic [11:0] py;
    logic [19:0] qx;
  } cmd_t;

  // fields from the highest bit down, matching out_tdata[40:0]
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  redos;
    logic [8:0]  lines;
    logic [19:0] height;
    logic        found;
  } reply_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class reply_board;
    logic [47:0] segs[pshq_pkg::MaxSegments];
    logic [47:0] redo[pshq_pkg::MaxSegments];
    int seg_top, redo_top;
    logic [11:0] ax, ay;
    reply_t pending[$];

    function void clear();
      seg_top = 0; redo_top = 0; ax = 0; ay = 0;
      pending.delete();
    endfunction

    function void note_item(cmd_t c);
      reply_t r;
      longint x1, y1, x2, y2, num;
      r = '0;
      case (c.func)
        pshq_pkg::FUNC_CLICK: begin
          if (ax == 0 && ay == 0) begin
            ax = c.px; ay = c.py;
          end else if (seg_top >= pshq_pkg::MaxSegments) r.status = pshq_pkg::ST_FULL;
          else begin
            segs[seg_top] = {ax, ay, c.px, c.py};
            seg_top++;
            ax = c.px; ay = c.py;
          end
        end
        pshq_pkg::FUNC_NEW: begin
          ax = 0; ay = 0;
        end
        pshq_pkg::FUNC_UNDO: begin
          if (seg_top == 0) r.status = pshq_pkg::ST_EMPTY;
          else if (redo_top >= pshq_pkg::MaxSegments) r.status = pshq_pkg::ST_FULL;
          else begin
            seg_top--;
            redo[redo_top] = segs[seg_top];
            redo_top++;
          end
        end
        pshq_pkg::FUNC_REDO: begin
          if (redo_top == 0) r.status = pshq_pkg::ST_EMPTY;
          else if (seg_top >= pshq_pkg::MaxSegments) r.status = pshq_pkg::ST_FULL;
          else begin
            redo_top--;
            segs[seg_top] = redo[redo_top];
            seg_top++;
          end
        end
        pshq_pkg::FUNC_QUERY: begin
          for (int i = 0; i < seg_top; i++) begin
            x1 = segs[i][47:36]; y1 = segs[i][35:24];
            x2 = segs[i][23:12]; y2 = segs[i][11:0];
            if (x1 * 256 < c.qx && c.qx < x2 * 256) begin
              num = y1 * 256 * (x2 - x1) + (y2 - y1) * (c.qx - x1 * 256);
              if (num < 0) num = 0;
              r.height = 20'(num / (x2 - x1));
              r.found = 1;
              break;
            end
          end
        end
        default: ;
      endcase
      r.lines = 9'(seg_top);
      r.redos = 9'(redo_top);
      pending = {pending, r};
    endfunction

    task check_reply(reply_t got);
      reply_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
        return;
      end
      w = pending.pop_front();
      if (got.found !== w.found) report_mismatch("found", got.found, w.found);
      if (got.height !== w.height) report_mismatch("height", got.height, w.height);
      if (got.lines !== w.lines) report_mismatch("line_count", got.lines, w.lines);
      if (got.redos !== w.redos) report_mismatch("redo_count", got.redos, w.redos);
      if (got.status !== w.status) report_mismatch("status", got.status, w.status);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0;
  logic [47:0] in_tdata = '0, out_tdata;
  reply_board board = new();
  bit calm_send = 0, calm_recv = 0, hold_recv = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  polyline_store_height_query uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  task automatic send_item(cmd_t c);
    if (!calm_send && $urandom_range(99) < 36) begin
      in_tvalid <= 0;
      do @(posedge clk); while (!calm_send && $urandom_range(99) < 36);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, c.qx, c.py, c.px, c.func};
    do @(posedge clk); while (!in_tready);
    board.note_item(c);
  endtask

  task automatic send(logic [2:0] f, int x = 0, int y = 0, int q = 0);
    cmd_t c;
    c.func = f; c.px = 12'(x); c.py = 12'(y); c.qx = 20'(q);
    send_item(c);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_x(int last);
    case ($urandom_range(3))
      0: return $urandom_range(4095);
      1: return $urandom_range(63);
      default: return (last + $urandom_range(200)) % 4096;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_reply(reply_t'(out_tdata[40:0]));
      out_tready <= !hold_recv && (calm_recv || $urandom_range(99) >= 36);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int lx, n;
    board.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed part
    send(pshq_pkg::FUNC_QUERY, 0, 0, 1000);
    send(pshq_pkg::FUNC_UNDO);
    send(pshq_pkg::FUNC_REDO);
    send(pshq_pkg::FUNC_CLICK, 0, 0);
    send(pshq_pkg::FUNC_CLICK, 10, 4095);
    send(pshq_pkg::FUNC_CLICK, 4095, 0);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 10 * 256);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 10 * 256 + 1);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 20000);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 4095 * 256 - 1);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 20'hfffff);
    send(pshq_pkg::FUNC_UNDO);
    send(pshq_pkg::FUNC_QUERY, 0, 0, 2 * 256);
    send(pshq_pkg::FUNC_REDO);
    send(pshq_pkg::FUNC_NEW);
    send(pshq_pkg::FUNC_CLICK, 4095, 4095);
    send(pshq_pkg::FUNC_CLICK, 0, 0);
    send(3'd5, 4095, 4095, 20'hfffff);
    send(3'd6);
    send(3'd7);
    // fill the line stack, then the redo stack, to reach the full cases
    calm_send = 1; calm_recv = 1;
    send(pshq_pkg::FUNC_NEW);
    for (int i = 0; i <= pshq_pkg::MaxSegments + 1; i++)
      send(pshq_pkg::FUNC_CLICK, i * 15 + 1, $urandom_range(4095));
    send(pshq_pkg::FUNC_QUERY, 0, 0, $urandom_range(20'hfffff));
    for (int i = 0; i <= pshq_pkg::MaxSegments; i++) send(pshq_pkg::FUNC_UNDO);
    for (int i = 0; i < 3; i++)
      send(pshq_pkg::FUNC_CLICK, $urandom_range(4095), $urandom_range(4095));
    for (int i = 0; i < 3; i++) send(pshq_pkg::FUNC_UNDO);
    for (int i = 0; i < 5; i++) send(pshq_pkg::FUNC_REDO);
    calm_send = 0; calm_recv = 0;
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      for (int i = 0; i < 8; i++) send(pshq_pkg::FUNC_QUERY, 0, 0, $urandom_range(20'hfffff));
    join
    wait_drained();
    lx = 0;
    for (int k = 0; k < 900; k++) begin
      if (k == 400) begin
        calm_send = 1; calm_recv = 1;
      end
      if (k == 550) begin
        calm_send = 0; calm_recv = 0;
      end
      if (k == 700) wait_drained();
      n = $urandom_range(99);
      if (n < 40) begin
        lx = pick_x(lx);
        send(pshq_pkg::FUNC_CLICK, lx, $urandom_range(4095));
      end else if (n < 45) send(pshq_pkg::FUNC_NEW);
      else if (n < 55) send(pshq_pkg::FUNC_UNDO);
      else if (n < 62) send(pshq_pkg::FUNC_REDO);
      else if (n < 95) begin
        if ($urandom_range(1)) send(pshq_pkg::FUNC_QUERY, 0, 0, $urandom_range(20'hfffff));
        else send(pshq_pkg::FUNC_QUERY, 0, 0, $urandom_range(lx * 256 + 300));
      end else send(3'($urandom_range(7)), $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(20'hfffff));
    end
    wait_drained();
    repeat (600) @(posedge clk);
    if (errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
rtl/pshq_pkg.sv
rtl/polyline_store_height_query.sv
sim/polyline_store_height_query_test.sv
